// ===== rtl/rdat_pkg.sv =====
// ----------------------------------------------------------------------------
// Rotary drag angle tracker package
// Shared constants, command codes, status types and helper functions.
// ----------------------------------------------------------------------------
`default_nettype none

package rdat_pkg;

  localparam int ANGLE_FRAC_BITS = 6;
  localparam int CORDIC_STEPS    = 16;

  // A quarter turn and a full turn in output angle units.
  localparam logic [14:0] QUARTER   = 15'(90 << ANGLE_FRAC_BITS);
  localparam logic [14:0] FULL_TURN = 15'(360 << ANGLE_FRAC_BITS);

  // Upper clamp of the rotation accumulator: 90 degrees in Q16.
  localparam logic signed [23:0] Z_MAX = 24'sd5898240;

  // Configuration register indexes.
  localparam logic [2:0] REG_CAP_CX  = 3'd0;
  localparam logic [2:0] REG_CAP_CY  = 3'd1;
  localparam logic [2:0] REG_RING_CX = 3'd2;
  localparam logic [2:0] REG_RING_CY = 3'd3;
  localparam logic [2:0] REG_CAP_R   = 3'd4;
  localparam logic [2:0] REG_RING_R  = 3'd5;

  // Datapath commands issued by the controller.
  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_DIFF,
    CMD_SQA,
    CMD_SQB,
    CMD_RINIT,
    CMD_RSTEP,
    CMD_CINIT,
    CMD_CSTEP,
    CMD_ANGLE,
    CMD_PR2,
    CMD_PU2,
    CMD_PNUM,
    CMD_DINIT,
    CMD_DSTEP,
    CMD_QINIT,
    CMD_PSAVE,
    CMD_FIN
  } rdat_op_e;

  typedef struct packed {
    rdat_op_e op;
  } rdat_cmd_t;

  typedef struct packed {
    logic last;      // step counter reached its limit
    logic outside;   // pointer lies beyond the dial radius
    logic axis;      // projection works on y when set
    logic out_busy;  // output register holds an item not yet taken
  } rdat_stat_t;

  // Rounded arctangent of 2^-i in degrees, Q16.
  function automatic logic [22:0] atan_entry(input logic [4:0] i);
    logic [22:0] v;
    case (i)
      5'd0:  v = 23'd2949120;
      5'd1:  v = 23'd1740967;
      5'd2:  v = 23'd919879;
      5'd3:  v = 23'd466945;
      5'd4:  v = 23'd234379;
      5'd5:  v = 23'd117304;
      5'd6:  v = 23'd58666;
      5'd7:  v = 23'd29335;
      5'd8:  v = 23'd14668;
      5'd9:  v = 23'd7334;
      5'd10: v = 23'd3667;
      5'd11: v = 23'd1833;
      5'd12: v = 23'd917;
      5'd13: v = 23'd458;
      5'd14: v = 23'd229;
      5'd15: v = 23'd115;
      5'd16: v = 23'd57;
      5'd17: v = 23'd29;
      5'd18: v = 23'd14;
      5'd19: v = 23'd7;
      5'd20: v = 23'd4;
      5'd21: v = 23'd2;
      5'd22: v = 23'd1;
      default: v = 23'd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    logic signed [31:0] r;
    if (v > 36'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -36'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
    logic signed [15:0] r;
    if (v > 18'sd32767) begin
      r = 16'sh7FFF;
    end else if (v < -18'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/rdat_if.sv =====
// ----------------------------------------------------------------------------
// Rotary drag angle tracker channels
// Valid/ready channels for pointer items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface rdat_in_if;
  logic               valid;
  logic               ready;
  logic               dial;
  logic               drag_start;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;

  modport source (output valid, dial, drag_start, pos_x, pos_y, input ready);
  modport sink   (input valid, dial, drag_start, pos_x, pos_y, output ready);
endinterface

interface rdat_out_if;
  logic               valid;
  logic               ready;
  logic        [14:0] angle;
  logic        [2:0]  quadrant;
  logic        [16:0] distance;
  logic signed [31:0] roll;
  logic               clockwise;
  logic signed [15:0] cursor_x;
  logic signed [15:0] cursor_y;

  modport source (output valid, angle, quadrant, distance, roll, clockwise,
                  cursor_x, cursor_y, input ready);
  modport sink   (input valid, angle, quadrant, distance, roll, clockwise,
                  cursor_x, cursor_y, output ready);
endinterface

`default_nettype wire

// ===== rtl/rotary_drag_angle_tracker_top.sv =====
// ----------------------------------------------------------------------------
// Rotary drag angle tracker
// Angle, distance, unwrapped roll and clamped cursor for two pointer dials.
// ----------------------------------------------------------------------------
// Every item runs the differences, squares, distance root, CORDIC loop and
// angle; beyond the radius the projection adds two 24-step divides and two
// 12-step roots. One item at a time; the 17-step distance root and the
// 16-step CORDIC loop set the minimum time per item.
// Reset: asynchronous, active low; radii return to 60 and 80, centers and
// all per-dial tracking state to zero.
`default_nettype none

module rotary_drag_angle_tracker_top import rdat_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_data_i,
  rdat_in_if.sink          item_in,
  rdat_out_if.source       result_out
);

  rdat_cmd_t  cmd;
  rdat_stat_t stat;

  // Sequencer.
  rdat_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (item_in.valid),
    .in_ready_o (item_in.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Arithmetic and state.
  rdat_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .in_dial_i       (item_in.dial),
    .in_start_i      (item_in.drag_start),
    .in_pos_x_i      (item_in.pos_x),
    .in_pos_y_i      (item_in.pos_y),
    .out_valid_o     (result_out.valid),
    .out_ready_i     (result_out.ready),
    .out_angle_o     (result_out.angle),
    .out_quadrant_o  (result_out.quadrant),
    .out_distance_o  (result_out.distance),
    .out_roll_o      (result_out.roll),
    .out_clockwise_o (result_out.clockwise),
    .out_cursor_x_o  (result_out.cursor_x),
    .out_cursor_y_o  (result_out.cursor_y)
  );

endmodule

`default_nettype wire

// ===== rtl/rdat_ctrl.sv =====
// ----------------------------------------------------------------------------
// Rotary drag angle tracker controller
// Sequences the datapath through root, rotation and projection phases.
// ----------------------------------------------------------------------------
`default_nettype none

module rdat_ctrl import rdat_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  rdat_stat_t      stat_i,
  output rdat_cmd_t       cmd_o
);

  typedef enum logic [17:0] {
    ST_IDLE  = 18'h00001,
    ST_DIFF  = 18'h00002,
    ST_SQA   = 18'h00004,
    ST_SQB   = 18'h00008,
    ST_RINIT = 18'h00010,
    ST_ROOT  = 18'h00020,
    ST_CINIT = 18'h00040,
    ST_ROT   = 18'h00080,
    ST_ANG   = 18'h00100,
    ST_PR2   = 18'h00200,
    ST_PU2   = 18'h00400,
    ST_PNUM  = 18'h00800,
    ST_DINIT = 18'h01000,
    ST_DIV   = 18'h02000,
    ST_QINIT = 18'h04000,
    ST_QROOT = 18'h08000,
    ST_PSAVE = 18'h10000,
    ST_FIN   = 18'h20000
  } rdat_state_e;

  rdat_state_e state_q, state_d;

  // Next state and command for the current phase.
  always_comb begin
    state_d    = state_q;
    cmd_o.op   = CMD_NONE;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = CMD_LOAD;
          state_d  = ST_DIFF;
        end
      end
      ST_DIFF: begin
        cmd_o.op = CMD_DIFF;
        state_d  = ST_SQA;
      end
      ST_SQA: begin
        cmd_o.op = CMD_SQA;
        state_d  = ST_SQB;
      end
      ST_SQB: begin
        cmd_o.op = CMD_SQB;
        state_d  = ST_RINIT;
      end
      ST_RINIT: begin
        cmd_o.op = CMD_RINIT;
        state_d  = ST_ROOT;
      end
      ST_ROOT: begin
        cmd_o.op = CMD_RSTEP;
        if (stat_i.last) state_d = ST_CINIT;
      end
      ST_CINIT: begin
        cmd_o.op = CMD_CINIT;
        state_d  = ST_ROT;
      end
      ST_ROT: begin
        cmd_o.op = CMD_CSTEP;
        if (stat_i.last) state_d = ST_ANG;
      end
      ST_ANG: begin
        cmd_o.op = CMD_ANGLE;
        state_d  = stat_i.outside ? ST_PR2 : ST_FIN;
      end
      ST_PR2: begin
        cmd_o.op = CMD_PR2;
        state_d  = ST_PU2;
      end
      ST_PU2: begin
        cmd_o.op = CMD_PU2;
        state_d  = ST_PNUM;
      end
      ST_PNUM: begin
        cmd_o.op = CMD_PNUM;
        state_d  = ST_DINIT;
      end
      ST_DINIT: begin
        cmd_o.op = CMD_DINIT;
        state_d  = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.op = CMD_DSTEP;
        if (stat_i.last) state_d = ST_QINIT;
      end
      ST_QINIT: begin
        cmd_o.op = CMD_QINIT;
        state_d  = ST_QROOT;
      end
      ST_QROOT: begin
        cmd_o.op = CMD_RSTEP;
        if (stat_i.last) state_d = ST_PSAVE;
      end
      ST_PSAVE: begin
        cmd_o.op = CMD_PSAVE;
        state_d  = stat_i.axis ? ST_FIN : ST_PU2;
      end
      ST_FIN: begin
        if (!stat_i.out_busy) begin
          cmd_o.op = CMD_FIN;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rdat_dp.sv =====
// ----------------------------------------------------------------------------
// Rotary drag angle tracker datapath
// Config registers, shared root/CORDIC/divide units, dial state and output.
// ----------------------------------------------------------------------------
`default_nettype none

module rdat_dp import rdat_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic        [2:0]  cfg_idx_i,
  input  wire logic        [15:0] cfg_data_i,
  input  rdat_cmd_t               cmd_i,
  output rdat_stat_t              stat_o,
  input  wire logic               in_dial_i,
  input  wire logic               in_start_i,
  input  wire logic signed [15:0] in_pos_x_i,
  input  wire logic signed [15:0] in_pos_y_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic             [14:0] out_angle_o,
  output logic             [2:0]  out_quadrant_o,
  output logic             [16:0] out_distance_o,
  output logic signed      [31:0] out_roll_o,
  output logic                    out_clockwise_o,
  output logic signed      [15:0] out_cursor_x_o,
  output logic signed      [15:0] out_cursor_y_o
);

  // Configuration, indexed by dial.
  logic signed [15:0] cx_q [2];
  logic signed [15:0] cy_q [2];
  logic        [11:0] rad_q [2];

  // Per-dial tracking state.
  logic        [2:0]  lastq_q [2];
  logic signed [31:0] wrap_q  [2];
  logic signed [31:0] lastu_q [2];
  logic signed [31:0] roll_q  [2];

  // Item and work registers.
  logic               dial_q, start_q, axis_q, outside_q;
  logic signed [15:0] px_q, py_q;
  logic signed [16:0] dx_q, dy_q;
  logic        [15:0] ax_q, ay_q;
  logic        [33:0] sq_q;
  logic        [35:0] rn_q, rr_q, rb_q;
  logic        [16:0] dist_q;
  logic signed [35:0] x_q, y_q;
  logic signed [23:0] z_q;
  logic        [14:0] ang_q;
  logic        [2:0]  quad_q;
  logic        [23:0] r2_q;
  logic        [31:0] u2_q;
  logic        [55:0] num_q;
  logic        [33:0] rem_q;
  logic        [23:0] lo_q, quo_q;
  logic signed [15:0] curx_q, cury_q;
  logic        [4:0]  cnt_q, lim_q;
  logic               out_valid_q;

  logic signed [15:0] cx_sel, cy_sel;
  logic        [11:0] rad_sel;
  assign cx_sel  = cx_q[dial_q];
  assign cy_sel  = cy_q[dial_q];
  assign rad_sel = rad_q[dial_q];

  assign stat_o.last     = (cnt_q == lim_q);
  assign stat_o.outside  = outside_q;
  assign stat_o.axis     = axis_q;
  assign stat_o.out_busy = out_valid_q && !out_ready_i;

  // Differences to the center.
  logic signed [16:0] dx_d, dy_d;
  logic signed [16:0] adx, ady;
  assign dx_d = 17'(cx_sel) - 17'(px_q);
  assign dy_d = 17'(cy_sel) - 17'(py_q);
  assign adx  = dx_d[16] ? -dx_d : dx_d;
  assign ady  = dy_d[16] ? -dy_d : dy_d;

  // Integer square root, one result bit per step.
  logic [35:0] rsum;
  logic        rge;
  assign rsum = rr_q + rb_q;
  assign rge  = (rn_q >= rsum);

  // CORDIC vectoring step.
  logic signed [35:0] xs, ys;
  assign xs = x_q >>> cnt_q;
  assign ys = y_q >>> cnt_q;

  // Restoring divide step against the squared distance.
  logic [34:0] rem2, ddiff;
  logic        dge;
  assign rem2  = {rem_q, lo_q[23]};
  assign dge   = (rem2 >= {1'b0, sq_q});
  assign ddiff = rem2 - {1'b0, sq_q};

  // First-quadrant angle and the quadrant mapping.
  logic signed [23:0] zc;
  logic        [23:0] zr;
  logic        [14:0] t_d, ang_d;
  logic        [2:0]  quad_d;
  always_comb begin
    if (z_q < 0) begin
      zc = '0;
    end else if (z_q > Z_MAX) begin
      zc = Z_MAX;
    end else begin
      zc = z_q;
    end
    zr = zc + 24'(1 << (15 - ANGLE_FRAC_BITS));
    if (ay_q == '0) begin
      t_d = '0;
    end else if (ax_q == '0) begin
      t_d = QUARTER;
    end else begin
      t_d = 15'(zr >> (16 - ANGLE_FRAC_BITS));
    end
    if (dx_q == '0 && dy_q == '0) begin
      ang_d = '0;
      quad_d = 3'd1;
    end else if (dx_q <= 0 && dy_q >= 0) begin
      ang_d = QUARTER - t_d;
      quad_d = 3'd1;
    end else if (dx_q <= 0 && dy_q <= 0) begin
      ang_d = QUARTER + t_d;
      quad_d = 3'd2;
    end else if (dx_q >= 0 && dy_q <= 0) begin
      ang_d = 15'(3 * QUARTER) - t_d;
      quad_d = 3'd3;
    end else begin
      ang_d = 15'(3 * QUARTER) + t_d;
      quad_d = 3'd4;
    end
  end

  // Projected coordinate for the current axis.
  logic signed [15:0] pc;
  logic               pneg;
  logic signed [17:0] psum;
  assign pc   = axis_q ? cy_sel : cx_sel;
  assign pneg = axis_q ? (dy_q > 0) : (dx_q > 0);
  assign psum = pneg ? (18'(pc) - 18'({6'b0, rr_q[11:0]}))
                     : (18'(pc) + 18'({6'b0, rr_q[11:0]}));

  // Unwrap and roll update for the finishing item.
  logic signed [33:0] off_d;
  logic signed [31:0] wrap_n, lastu_n, roll_n;
  logic signed [34:0] chg;
  always_comb begin
    off_d = 34'(wrap_q[dial_q]);
    if (lastq_q[dial_q] == 3'd4 && quad_q == 3'd1) begin
      off_d = off_d + 34'(FULL_TURN);
    end
    if (lastq_q[dial_q] == 3'd1 && quad_q == 3'd4) begin
      off_d = off_d - 34'(FULL_TURN);
    end
    wrap_n  = sat32(36'(off_d));
    chg     = 35'({1'b0, ang_q}) + 35'(wrap_n) - 35'(lastu_q[dial_q]);
    lastu_n = sat32(36'({1'b0, ang_q}) + 36'(wrap_n));
    roll_n  = sat32(36'(roll_q[dial_q]) + 36'(chg));
    if (start_q) begin
      wrap_n  = '0;
      lastu_n = 32'({17'b0, ang_q});
      roll_n  = roll_q[dial_q];
      chg     = '0;
    end
  end

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q[0]  <= '0;
      cx_q[1]  <= '0;
      cy_q[0]  <= '0;
      cy_q[1]  <= '0;
      rad_q[0] <= 12'd60;
      rad_q[1] <= 12'd80;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_CAP_CX:  cx_q[0]  <= cfg_data_i;
        REG_CAP_CY:  cy_q[0]  <= cfg_data_i;
        REG_RING_CX: cx_q[1]  <= cfg_data_i;
        REG_RING_CY: cy_q[1]  <= cfg_data_i;
        REG_CAP_R:   rad_q[0] <= cfg_data_i[11:0];
        REG_RING_R:  rad_q[1] <= cfg_data_i[11:0];
        default: ;
      endcase
    end
  end

  // Dial state and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 2; k++) begin
        lastq_q[k] <= '0;
        wrap_q[k]  <= '0;
        lastu_q[k] <= '0;
        roll_q[k]  <= '0;
      end
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      if (cmd_i.op == CMD_FIN) begin
        lastq_q[dial_q] <= quad_q;
        wrap_q[dial_q]  <= wrap_n;
        lastu_q[dial_q] <= lastu_n;
        roll_q[dial_q]  <= roll_n;
        out_valid_q     <= 1'b1;
      end
    end
  end

  // Work registers, driven by the controller's command.
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      CMD_LOAD: begin
        dial_q  <= in_dial_i;
        start_q <= in_start_i;
        px_q    <= in_pos_x_i;
        py_q    <= in_pos_y_i;
        axis_q  <= 1'b0;
      end
      CMD_DIFF: begin
        dx_q <= dx_d;
        dy_q <= dy_d;
        ax_q <= adx[15:0];
        ay_q <= ady[15:0];
      end
      CMD_SQA: sq_q <= {2'b0, 32'(ax_q) * 32'(ax_q)};
      CMD_SQB: sq_q <= sq_q + {2'b0, 32'(ay_q) * 32'(ay_q)};
      CMD_RINIT: begin
        rn_q  <= {2'b0, sq_q};
        rr_q  <= '0;
        rb_q  <= 36'h1_0000_0000;
        cnt_q <= '0;
        lim_q <= 5'd16;
      end
      CMD_RSTEP: begin
        rn_q  <= rge ? rn_q - rsum : rn_q;
        rr_q  <= rge ? (rr_q >> 1) + rb_q : rr_q >> 1;
        rb_q  <= rb_q >> 2;
        cnt_q <= cnt_q + 5'd1;
      end
      CMD_CINIT: begin
        dist_q    <= rr_q[16:0];
        outside_q <= (rr_q > {24'b0, rad_sel});
        x_q       <= {4'b0, ax_q, 16'b0};
        y_q       <= {4'b0, ay_q, 16'b0};
        z_q       <= '0;
        cnt_q     <= '0;
        lim_q     <= 5'(CORDIC_STEPS - 1);
      end
      CMD_CSTEP: begin
        if (!y_q[35]) begin
          x_q <= x_q + ys;
          y_q <= y_q - xs;
          z_q <= z_q + 24'(atan_entry(cnt_q));
        end else begin
          x_q <= x_q - ys;
          y_q <= y_q + xs;
          z_q <= z_q - 24'(atan_entry(cnt_q));
        end
        cnt_q <= cnt_q + 5'd1;
      end
      CMD_ANGLE: begin
        ang_q  <= ang_d;
        quad_q <= quad_d;
      end
      CMD_PR2: r2_q <= 24'(rad_sel * rad_sel);
      CMD_PU2: u2_q <= axis_q ? ay_q * ay_q : ax_q * ax_q;
      CMD_PNUM: num_q <= 56'(r2_q * u2_q);
      CMD_DINIT: begin
        rem_q <= {2'b0, num_q[55:24]};
        lo_q  <= num_q[23:0];
        quo_q <= '0;
        cnt_q <= '0;
        lim_q <= 5'd23;
      end
      CMD_DSTEP: begin
        rem_q <= dge ? ddiff[33:0] : rem2[33:0];
        lo_q  <= {lo_q[22:0], 1'b0};
        quo_q <= {quo_q[22:0], dge};
        cnt_q <= cnt_q + 5'd1;
      end
      CMD_QINIT: begin
        rn_q  <= {12'b0, quo_q};
        rr_q  <= '0;
        rb_q  <= 36'h40_0000;
        cnt_q <= '0;
        lim_q <= 5'd11;
      end
      CMD_PSAVE: begin
        if (axis_q) begin
          cury_q <= sat16(psum);
        end else begin
          curx_q <= sat16(psum);
        end
        axis_q <= ~axis_q;
      end
      CMD_FIN: begin
        out_angle_o     <= ang_q;
        out_quadrant_o  <= quad_q;
        out_distance_o  <= dist_q;
        out_roll_o      <= roll_n;
        out_clockwise_o <= (chg > 0);
        out_cursor_x_o  <= outside_q ? curx_q : px_q;
        out_cursor_y_o  <= outside_q ? cury_q : py_q;
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;

  // A finished item always shows up on the output next cycle.
  a_fin_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == CMD_FIN |=> out_valid_q)
    else $error("finished item did not reach the output register");

  // The output register is never overwritten while it still holds an item.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == CMD_FIN |-> !(out_valid_q && !out_ready_i))
    else $error("output register overwritten");

  // Step commands never run past the step counter's limit.
  a_cnt_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == CMD_RSTEP || cmd_i.op == CMD_CSTEP || cmd_i.op == CMD_DSTEP)
      |-> cnt_q <= lim_q)
    else $error("step counter ran past its limit");

endmodule

`default_nettype wire

// ===== sim/tb_rotary_drag_angle_tracker_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotary drag angle tracker testbench
// Drives pointer items for both dials through the valid/ready channels,
// predicts angle, quadrant, distance, roll and cursor for every accepted item
// and compares each result in order. Directed corner cases and dial setups
// come first, then random drag sequences with idle bursts, a long receiver
// hold-off and a final stretch at full rate.
// ----------------------------------------------------------------------------
module tb_rotary_drag_angle_tracker_top;
  import rdat_pkg::*;

  localparam int  HALF_PERIOD = 4;
  localparam int  CYCLE_LIMIT = 800000;
  localparam int  DRAIN_WAIT  = 130;
  localparam int  LONG_HOLD   = 400;
  localparam longint UNIT_Q   = 64'd90 << ANGLE_FRAC_BITS;
  // Indexes beyond the register file; writes to them must change nothing.
  localparam logic [2:0] REG_SPARE_6 = 3'd6;
  localparam logic [2:0] REG_SPARE_7 = 3'd7;
  localparam logic       DIAL_CAP    = 1'b0;
  localparam logic       DIAL_RING   = 1'b1;

  // Rounded arctangent of 2^-i in degrees, Q16.
  localparam longint ARCTAN_Q16 [16] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115
  };

  typedef struct {
    logic        [14:0] angle;
    logic        [2:0]  quadrant;
    logic        [16:0] distance;
    logic signed [31:0] roll;
    logic               clockwise;
    logic signed [15:0] cursor_x;
    logic signed [15:0] cursor_y;
  } dial_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [15:0] cfg_data_i;

  rdat_in_if  in_if ();
  rdat_out_if out_if ();

  rotary_drag_angle_tracker_top uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .item_in    (in_if),
    .result_out (out_if)
  );

  // Mirror of the dial setup and tracking state.
  logic signed [15:0] center_x [2];
  logic signed [15:0] center_y [2];
  logic        [11:0] radius   [2];
  logic        [2:0]  prev_quadrant [2];
  logic signed [31:0] wrap_turns    [2];
  logic signed [31:0] prev_unwrapped [2];
  logic signed [31:0] roll_sum      [2];

  dial_result_t pending_results [$];
  int   fail_count = 0;
  int   cycle_count = 0;
  bit   idle_enable = 1'b0;
  bit   long_hold_req = 1'b0;
  int   hold_left = 0;

  always begin
    #HALF_PERIOD clk_i = 1'b1;
    #HALF_PERIOD clk_i = 1'b0;
  end

  // Cycle limit.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_rotary_drag_angle_tracker_top NOT OK");
      $finish;
    end
  end

  function automatic longint clamp_s32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint clamp_s16(input longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned n);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // First-quadrant angle atan(ay/ax) by vectoring, in output units.
  function automatic longint vector_angle(input longint ax, input longint ay);
    longint x;
    longint y;
    longint z;
    longint xs;
    longint ys;
    x = ax <<< 16;
    y = ay <<< 16;
    z = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x += ys; y -= xs; z += ARCTAN_Q16[i];
      end else begin
        x -= ys; y += xs; z -= ARCTAN_Q16[i];
      end
    end
    if (z < 0) z = 0;
    if (z > (64'sd90 <<< 16)) z = 64'sd90 <<< 16;
    return (z + (64'sd1 <<< (15 - ANGLE_FRAC_BITS))) >>> (16 - ANGLE_FRAC_BITS);
  endfunction

  // One axis of the cursor projected onto the dial circle.
  function automatic longint circle_point(input longint c, input longint u,
                                          input longint unsigned r,
                                          input longint unsigned d2);
    longint unsigned au;
    longint unsigned q;
    au = (u < 0) ? -u : u;
    q = int_sqrt((r * r * au * au) / d2);
    return clamp_s16((u < 0) ? c - longint'(q) : c + longint'(q));
  endfunction

  // Advances the dial tracking state and returns the expected result.
  function automatic dial_result_t track_pointer(input logic d, input logic start,
                                                 input logic signed [15:0] px,
                                                 input logic signed [15:0] py);
    dial_result_t res;
    longint dx;
    longint dy;
    longint ax;
    longint ay;
    longint unsigned d2;
    longint unsigned root_dist;
    longint t;
    longint angle;
    longint change;
    longint off;
    logic [2:0] quad;
    dx = longint'(center_x[d]) - longint'(px);
    dy = longint'(center_y[d]) - longint'(py);
    ax = (dx < 0) ? -dx : dx;
    ay = (dy < 0) ? -dy : dy;
    d2 = ax * ax + ay * ay;
    root_dist = int_sqrt(d2);
    change = 0;
    if (ay == 0) t = 0;
    else if (ax == 0) t = UNIT_Q;
    else t = vector_angle(ax, ay);

    if (dx == 0 && dy == 0) begin
      angle = 0; quad = 3'd1;
    end else if (dx <= 0 && dy >= 0) begin
      angle = UNIT_Q - t; quad = 3'd1;
    end else if (dx <= 0 && dy <= 0) begin
      angle = UNIT_Q + t; quad = 3'd2;
    end else if (dx >= 0 && dy <= 0) begin
      angle = 3 * UNIT_Q - t; quad = 3'd3;
    end else begin
      angle = 3 * UNIT_Q + t; quad = 3'd4;
    end

    // A drag start rebases the reference; other items unwrap and accumulate.
    if (start) begin
      wrap_turns[d] = 0;
      prev_unwrapped[d] = clamp_s32(angle);
    end else begin
      off = wrap_turns[d];
      if (prev_quadrant[d] == 3'd4 && quad == 3'd1) off += 4 * UNIT_Q;
      if (prev_quadrant[d] == 3'd1 && quad == 3'd4) off -= 4 * UNIT_Q;
      wrap_turns[d] = clamp_s32(off);
      change = angle + longint'(wrap_turns[d]) - longint'(prev_unwrapped[d]);
      prev_unwrapped[d] = clamp_s32(angle + longint'(wrap_turns[d]));
      roll_sum[d] = clamp_s32(longint'(roll_sum[d]) + change);
    end
    prev_quadrant[d] = quad;

    if (root_dist <= longint'(radius[d])) begin
      res.cursor_x = px;
      res.cursor_y = py;
    end else begin
      res.cursor_x = 16'(circle_point(center_x[d], -dx, radius[d], d2));
      res.cursor_y = 16'(circle_point(center_y[d], -dy, radius[d], d2));
    end
    res.angle = 15'(angle);
    res.quadrant = quad;
    res.distance = 17'(root_dist);
    res.roll = roll_sum[d];
    res.clockwise = (change > 0);
    return res;
  endfunction

  // Receiver readiness: random stall bursts plus a long requested hold-off.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else if (long_hold_req) begin
      long_hold_req <= 1'b0;
      hold_left <= LONG_HOLD;
      out_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_if.ready <= 1'b0;
    end else if (idle_enable && $urandom_range(0, 5) == 0) begin
      hold_left <= $urandom_range(0, 7);
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // Result checker: compares each accepted result with the oldest prediction.
  always @(posedge clk_i) begin
    dial_result_t exp_res;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_results.size() == 0) begin
        $error("result with no prediction waiting");
        fail_count++;
      end else begin
        exp_res = pending_results.pop_front();
        if (out_if.angle !== exp_res.angle) begin
          $error("angle: expected %0d, got %0d", exp_res.angle, out_if.angle);
          fail_count++;
        end
        if (out_if.quadrant !== exp_res.quadrant) begin
          $error("quadrant: expected %0d, got %0d", exp_res.quadrant, out_if.quadrant);
          fail_count++;
        end
        if (out_if.distance !== exp_res.distance) begin
          $error("distance: expected %0d, got %0d", exp_res.distance, out_if.distance);
          fail_count++;
        end
        if (out_if.roll !== exp_res.roll) begin
          $error("roll: expected %0d, got %0d", exp_res.roll, out_if.roll);
          fail_count++;
        end
        if (out_if.clockwise !== exp_res.clockwise) begin
          $error("clockwise: expected %0d, got %0d", exp_res.clockwise,
                 out_if.clockwise);
          fail_count++;
        end
        if (out_if.cursor_x !== exp_res.cursor_x) begin
          $error("cursor_x: expected %0d, got %0d", exp_res.cursor_x, out_if.cursor_x);
          fail_count++;
        end
        if (out_if.cursor_y !== exp_res.cursor_y) begin
          $error("cursor_y: expected %0d, got %0d", exp_res.cursor_y, out_if.cursor_y);
          fail_count++;
        end
      end
    end
  end

  // Sends one pointer item; valid stays high unless an idle burst follows.
  task automatic send_pointer(input logic d, input logic start,
                              input logic signed [15:0] px,
                              input logic signed [15:0] py);
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.dial <= d;
    in_if.drag_start <= start;
    in_if.pos_x <= px;
    in_if.pos_y <= py;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    pending_results.push_back(track_pointer(d, start, px, py));
  endtask

  task automatic drain_results();
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_CAP_CX:  center_x[0] = data;
      REG_CAP_CY:  center_y[0] = data;
      REG_RING_CX: center_x[1] = data;
      REG_RING_CY: center_y[1] = data;
      REG_CAP_R:   radius[0] = data[11:0];
      REG_RING_R:  radius[1] = data[11:0];
      default: ;
    endcase
  endtask

  task automatic setup_dials(input logic signed [15:0] cx0, input logic signed [15:0] cy0,
                             input logic [15:0] r0, input logic signed [15:0] cx1,
                             input logic signed [15:0] cy1, input logic [15:0] r1);
    drain_results();
    write_reg(REG_CAP_CX, cx0);
    write_reg(REG_CAP_CY, cy0);
    write_reg(REG_CAP_R, r0);
    write_reg(REG_RING_CX, cx1);
    write_reg(REG_RING_CY, cy1);
    write_reg(REG_RING_R, r1);
  endtask

  function automatic logic signed [15:0] clip16(input int v);
    return 16'(clamp_s16(v));
  endfunction

  // Center point, the four axes, the quadrant interiors and field extremes.
  task automatic test_corner_positions();
    send_pointer(DIAL_CAP, 1'b1, 16'sd0, 16'sd0);
    send_pointer(DIAL_CAP, 1'b0, 16'sd0, -16'sd50);
    send_pointer(DIAL_CAP, 1'b0, 16'sd50, 16'sd0);
    send_pointer(DIAL_CAP, 1'b0, 16'sd0, 16'sd50);
    send_pointer(DIAL_CAP, 1'b0, -16'sd50, 16'sd0);
    send_pointer(DIAL_CAP, 1'b0, -16'sd30, -16'sd40);
    send_pointer(DIAL_CAP, 1'b0, 16'sd30, -16'sd40);
    send_pointer(DIAL_RING, 1'b0, 16'sd30, 16'sd40);
    send_pointer(DIAL_RING, 1'b0, -16'sd40, 16'sd30);
    send_pointer(DIAL_RING, 1'b0, 16'sh7FFF, 16'sh7FFF);
    send_pointer(DIAL_RING, 1'b0, -16'sh8000, -16'sh8000);
    send_pointer(DIAL_RING, 1'b1, 16'sh7FFF, -16'sh8000);
    send_pointer(DIAL_CAP, 1'b0, 16'sd0, 16'sd0);
  endtask

  // Repeated crossings between the upper-left and upper-right quadrants.
  task automatic test_wrap_crossings();
    send_pointer(DIAL_CAP, 1'b1, -16'sd10, -16'sd40);
    for (int k = 0; k < 3; k++) begin
      send_pointer(DIAL_CAP, 1'b0, 16'sd10, -16'sd40);
      send_pointer(DIAL_CAP, 1'b0, 16'sd40, 16'sd10);
      send_pointer(DIAL_CAP, 1'b0, -16'sd10, 16'sd40);
      send_pointer(DIAL_CAP, 1'b0, -16'sd40, -16'sd10);
    end
    send_pointer(DIAL_CAP, 1'b0, 16'sd10, -16'sd40);
    send_pointer(DIAL_CAP, 1'b0, -16'sd10, -16'sd40);
    send_pointer(DIAL_CAP, 1'b1, 16'sd10, -16'sd40);
  endtask

  // Extreme centers and radii, including writes to unused indexes.
  task automatic test_register_extremes();
    setup_dials(-16'sh8000, 16'sh7FFF, 16'hF000, 16'sh7FFF, -16'sh8000, 16'h0FFF);
    write_reg(REG_SPARE_6, 16'hFFFF);
    write_reg(REG_SPARE_7, 16'h1234);
    send_pointer(DIAL_CAP, 1'b1, 16'sh7FFF, -16'sh8000);
    send_pointer(DIAL_CAP, 1'b0, -16'sh8000, 16'sh7FFF);
    send_pointer(DIAL_RING, 1'b1, -16'sh8000, 16'sh7FFF);
    send_pointer(DIAL_RING, 1'b0, 16'sh7000, -16'sh7000);
    send_pointer(DIAL_RING, 1'b0, 16'sh7FFF, -16'sh8000);
    setup_dials(16'sd100, -16'sd200, 16'hFFFF, -16'sd300, 16'sd400, 16'h0001);
    send_pointer(DIAL_CAP, 1'b0, 16'sd100, -16'sd200);
    send_pointer(DIAL_RING, 1'b0, -16'sd300, 16'sd399);
    send_pointer(DIAL_RING, 1'b0, -16'sd1000, 16'sd2000);
  endtask

  // Well-formed drags with random walks, mixed with full-range noise.
  task automatic test_random_drags(input int n_items);
    int sent;
    int steps;
    int step_dist;
    logic d;
    logic signed [15:0] px;
    logic signed [15:0] py;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 9) == 0) begin
        send_pointer($urandom_range(0, 1), $urandom_range(0, 1), $urandom, $urandom);
        sent++;
      end else begin
        d = $urandom_range(0, 1);
        step_dist = (radius[d] > 4) ? radius[d] : 40;
        px = clip16(int'(center_x[d]) + $urandom_range(0, 2 * step_dist) - step_dist);
        py = clip16(int'(center_y[d]) + $urandom_range(0, 2 * step_dist) - step_dist);
        send_pointer(d, ($urandom_range(0, 4) != 0), px, py);
        sent++;
        steps = $urandom_range(3, 20);
        for (int k = 0; k < steps && sent < n_items; k++) begin
          px = clip16(int'(px) + $urandom_range(0, step_dist) - step_dist / 2);
          py = clip16(int'(py) + $urandom_range(0, step_dist) - step_dist / 2);
          send_pointer(d, 1'b0, px, py);
          sent++;
        end
      end
    end
  endtask

  // The receiver holds off while items keep coming, so the input stalls.
  task automatic test_output_backpressure();
    long_hold_req <= 1'b1;
    for (int k = 0; k < 8; k++) begin
      send_pointer(k[0], (k == 0), 16'(k * 37 - 100), 16'(90 - k * 23));
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= REG_CAP_CX;
    cfg_data_i <= 16'h0000;
    in_if.valid <= 1'b0;
    in_if.dial <= 1'b0;
    in_if.drag_start <= 1'b0;
    in_if.pos_x <= 16'sd0;
    in_if.pos_y <= 16'sd0;
    for (int k = 0; k < 2; k++) begin
      center_x[k] = 0;
      center_y[k] = 0;
      prev_quadrant[k] = 0;
      wrap_turns[k] = 0;
      prev_unwrapped[k] = 0;
      roll_sum[k] = 0;
    end
    radius[0] = 12'd60;
    radius[1] = 12'd80;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_corner_positions();
    test_wrap_crossings();
    test_register_extremes();

    idle_enable = 1'b1;
    setup_dials(16'sd0, 16'sd0, 16'd60, 16'sd0, 16'sd0, 16'd80);
    test_output_backpressure();
    test_random_drags(250);
    setup_dials($urandom, $urandom, $urandom_range(0, 4095),
                $urandom, $urandom, $urandom_range(0, 4095));
    test_random_drags(200);
    setup_dials(-16'sd20000, 16'sd15000, 16'd0, 16'sd30000, -16'sd30000, 16'd4095);
    test_random_drags(200);
    setup_dials(16'sd500, 16'sd500, 16'd200, -16'sd500, -16'sd500, 16'd30);
    test_random_drags(100);
    idle_enable = 1'b0;
    test_random_drags(100);

    drain_results();
    if (fail_count == 0) begin
      $display("tb_rotary_drag_angle_tracker_top OK");
    end else begin
      $display("tb_rotary_drag_angle_tracker_top NOT OK");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/rdat_pkg.sv
rtl/rdat_if.sv
rtl/rdat_ctrl.sv
rtl/rdat_dp.sv
rtl/rotary_drag_angle_tracker_top.sv
sim/tb_rotary_drag_angle_tracker_top.sv
